// File: rtl/ramh_pkg.sv
// ----------------------------------------------------------------------------
// ramh_pkg: shared constants for the room allocator
// Field widths of the request and response streams and the default heap size.
// ----------------------------------------------------------------------------
package ramh_pkg;

   localparam int CAPACITY_DEFAULT = 1024;

   // Request fields.
   localparam int DEP_W = 32;
   localparam int TAG_W = 16;
   localparam int REQ_W = 2 * DEP_W + TAG_W;

   // Response fields: room and rooms_used are reported on 11 bits.
   localparam int OUT_W = 11;
   localparam int RSP_PAD_W = 2;
   localparam int RSP_W = 2 * OUT_W + TAG_W + RSP_PAD_W;

endpackage

// File: rtl/ramh_level_cell.sv
// ----------------------------------------------------------------------------
// ramh_level_cell: one level of the min-heap
// Holds every entry of one heap level in two banks (even and odd offsets) and
// performs one step of a sift-down or sift-up, handing the moving entry to
// the neighbouring level in the following cycle.
// ----------------------------------------------------------------------------
module ramh_level_cell
   import ramh_pkg::*;
#(
   parameter int LEVEL = 1,
   parameter int CNT_W = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CNT_W-1:0]         count_i,
   // Read request for this level, raised in the cycle before a token arrives.
   input  logic                     rd_en_i,
   input  logic [CNT_W-1:0]         rd_row_i,
   // Down token: entry wants the slot at level LEVEL-1, offset dtok_off_i.
   input  logic                     dtok_vld_i,
   input  logic [DEP_W+CNT_W-1:0]   dtok_val_i,
   input  logic [CNT_W-1:0]         dtok_off_i,
   // Up token: entry wants the slot at level LEVEL+1, offset utok_off_i.
   input  logic                     utok_vld_i,
   input  logic [DEP_W+CNT_W-1:0]   utok_val_i,
   input  logic [CNT_W-1:0]         utok_off_i,
   // Writes into this level from the level above and from the level below.
   input  logic                     wa_en_i,
   input  logic [CNT_W-1:0]         wa_off_i,
   input  logic [DEP_W+CNT_W-1:0]   wa_val_i,
   input  logic                     wb_en_i,
   input  logic [CNT_W-1:0]         wb_off_i,
   input  logic [DEP_W+CNT_W-1:0]   wb_val_i,
   // Towards the level below.
   output logic                     dtok_vld_o,
   output logic [DEP_W+CNT_W-1:0]   dtok_val_o,
   output logic [CNT_W-1:0]         dtok_off_o,
   output logic                     dn_rd_en_o,
   output logic [CNT_W-1:0]         dn_rd_row_o,
   output logic                     wd_en_o,
   output logic [CNT_W-1:0]         wd_off_o,
   output logic [DEP_W+CNT_W-1:0]   wd_val_o,
   // Towards the level above.
   output logic                     utok_vld_o,
   output logic [DEP_W+CNT_W-1:0]   utok_val_o,
   output logic [CNT_W-1:0]         utok_off_o,
   output logic                     up_rd_en_o,
   output logic [CNT_W-1:0]         up_rd_row_o,
   output logic                     wu_en_o,
   output logic [CNT_W-1:0]         wu_off_o,
   output logic [DEP_W+CNT_W-1:0]   wu_val_o,
   output logic                     fin_o
);

   localparam int ENT_W = DEP_W + CNT_W;
   localparam int ROW_W = (LEVEL > 1) ? LEVEL - 1 : 1;
   localparam int ROWS = 1 << ROW_W;
   localparam bit IS_LAST = (LEVEL == CNT_W - 1);
   localparam logic [CNT_W:0] LVL_BASE = {{CNT_W{1'b0}}, 1'b1} << LEVEL;

   logic [ENT_W-1:0] bank0_mem [ROWS];
   logic [ENT_W-1:0] bank1_mem [ROWS];
   logic [ENT_W-1:0] rd0_ff;
   logic [ENT_W-1:0] rd1_ff;

   logic             dtok_vld_ff, dtok_vld_in;
   logic [ENT_W-1:0] dtok_val_ff, dtok_val_in;
   logic [CNT_W-1:0] dtok_off_ff, dtok_off_in;
   logic             utok_vld_ff, utok_vld_in;
   logic [ENT_W-1:0] utok_val_ff, utok_val_in;
   logic [CNT_W-1:0] utok_off_ff, utok_off_in;

   logic             self_en;
   logic [CNT_W-1:0] self_off;
   logic [ENT_W-1:0] self_val;
   logic             wr_en;
   logic [CNT_W-1:0] wr_off;
   logic [ENT_W-1:0] wr_val;

   logic [CNT_W-1:0] d_co0, d_co1, d_mco;
   logic [CNT_W:0]   d_n0, d_n1;
   logic             d_c0v, d_c1v, d_sel1, d_swap;
   logic [ENT_W-1:0] d_min;
   logic [CNT_W-1:0] u_par;
   logic [ENT_W-1:0] u_pval;
   logic             u_swap;

   // Only one operation walks the heap at a time, so the write sources never
   // coincide.
   always_comb begin
      if (wa_en_i) begin
         wr_en  = 1'b1;
         wr_off = wa_off_i;
         wr_val = wa_val_i;
      end else if (wb_en_i) begin
         wr_en  = 1'b1;
         wr_off = wb_off_i;
         wr_val = wb_val_i;
      end else begin
         wr_en  = self_en;
         wr_off = self_off;
         wr_val = self_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !wr_off[0]) begin
         bank0_mem[wr_off[ROW_W:1]] <= wr_val;
      end
      if (wr_en && wr_off[0]) begin
         bank1_mem[wr_off[ROW_W:1]] <= wr_val;
      end
      if (rd_en_i) begin
         rd0_ff <= bank0_mem[rd_row_i[ROW_W-1:0]];
         rd1_ff <= bank1_mem[rd_row_i[ROW_W-1:0]];
      end
   end

   // Sift-down step: the two children of the parent slot sit in one row.
   assign d_co0  = {dtok_off_i[CNT_W-2:0], 1'b0};
   assign d_co1  = {dtok_off_i[CNT_W-2:0], 1'b1};
   assign d_n0   = LVL_BASE + {1'b0, d_co0};
   assign d_n1   = LVL_BASE + {1'b0, d_co1};
   assign d_c0v  = d_n0 <= {1'b0, count_i};
   assign d_c1v  = d_n1 <= {1'b0, count_i};
   assign d_sel1 = d_c1v && (rd1_ff < rd0_ff);
   assign d_min  = d_sel1 ? rd1_ff : rd0_ff;
   assign d_mco  = d_sel1 ? d_co1 : d_co0;
   assign d_swap = d_c0v && (d_min < dtok_val_i);

   // Sift-up step: the parent's bank is chosen by bit 1 of the child offset.
   assign u_par  = utok_off_i >> 1;
   assign u_pval = u_par[0] ? rd1_ff : rd0_ff;
   assign u_swap = u_pval > utok_val_i;

   always_comb begin
      dtok_vld_in = 1'b0;
      dtok_val_in = dtok_val_i;
      dtok_off_in = d_mco;
      dn_rd_en_o  = 1'b0;
      dn_rd_row_o = d_mco;
      utok_vld_in = 1'b0;
      utok_val_in = utok_val_i;
      utok_off_in = u_par;
      up_rd_en_o  = 1'b0;
      up_rd_row_o = u_par >> 2;
      wu_en_o     = 1'b0;
      wu_off_o    = dtok_off_i;
      wu_val_o    = dtok_val_i;
      wd_en_o     = 1'b0;
      wd_off_o    = utok_off_i;
      wd_val_o    = utok_val_i;
      self_en     = 1'b0;
      self_off    = d_mco;
      self_val    = dtok_val_i;
      fin_o       = 1'b0;
      if (dtok_vld_i) begin
         wu_en_o = 1'b1;
         if (d_swap) begin
            wu_val_o = d_min;
            if (IS_LAST) begin
               self_en = 1'b1;
               fin_o   = 1'b1;
            end else begin
               dtok_vld_in = 1'b1;
               dn_rd_en_o  = 1'b1;
            end
         end else begin
            fin_o = 1'b1;
         end
      end
      if (utok_vld_i) begin
         wd_en_o = 1'b1;
         if (u_swap) begin
            wd_val_o    = u_pval;
            utok_vld_in = 1'b1;
            up_rd_en_o  = 1'b1;
         end else begin
            fin_o = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dtok_vld_ff <= 1'b0;
         utok_vld_ff <= 1'b0;
      end else begin
         dtok_vld_ff <= dtok_vld_in;
         utok_vld_ff <= utok_vld_in;
      end
      dtok_val_ff <= dtok_val_in;
      dtok_off_ff <= dtok_off_in;
      utok_val_ff <= utok_val_in;
      utok_off_ff <= utok_off_in;
   end

   assign dtok_vld_o = dtok_vld_ff;
   assign dtok_val_o = dtok_val_ff;
   assign dtok_off_o = dtok_off_ff;
   assign utok_vld_o = utok_vld_ff;
   assign utok_val_o = utok_val_ff;
   assign utok_off_o = utok_off_ff;

endmodule

// File: rtl/room_allocator_min_heap.sv
// ----------------------------------------------------------------------------
// room_allocator_min_heap: interval partitioning room allocator
// Keeps a min-heap of (departure, room) pairs. A request reuses the room that
// frees earliest if it is free before the arrival, otherwise it opens a new
// room. The heap is a chain of level cells below a root register.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload (lowest bit first)                 transfer
//  req_     in         arrival, departure, request_tag            tvalid & tready
//  rsp_     out        room, rooms_used, tag_out; tuser=overflow  tvalid & tready
//
// The response is registered and appears in the cycle after the request
// transfer. The heap update walks the level chain at one level per cycle and
// the next request is taken in the cycle after the walk ends: a reuse walks
// its entry down level by level, a new room in level l >= 2 walks up level
// by level, and one in the top two levels needs no walk.
// A stalled response holds back the next request but not the heap update.
// Reset empties the heap at once; the level memories need no clearing.
// ----------------------------------------------------------------------------
module room_allocator_min_heap
   import ramh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // arrival, departure, request_tag
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // room, rooms_used, tag_out, zero pad
   output logic             rsp_tuser    // overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int NC = CNT_W - 1;
   localparam int ENT_W = DEP_W + CNT_W;
   localparam int LVL_W = $clog2(CNT_W + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [DEP_W-1:0] req_arrival, req_departure;
   logic [TAG_W-1:0] req_tag;

   logic             busy_ff;
   logic [ENT_W-1:0] root_ff;
   logic [CNT_W-1:0] count_ff;
   logic [LVL_W-1:0] slot_lvl_ff;
   logic [CNT_W-1:0] slot_off_ff;
   logic             inj_dn_ff, inj_up_ff;
   logic [LVL_W-1:0] inj_lvl_ff;
   logic [ENT_W-1:0] inj_val_ff;
   logic [CNT_W-1:0] inj_off_ff;

   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_room_ff, rsp_used_ff;
   logic             rsp_ovf_ff;
   logic [TAG_W-1:0] rsp_tag_ff;

   logic             accept, reuse, full, push;
   logic             push_root, push_l1, push_deep;
   logic [CNT_W-1:0] cnt_inc;
   logic [ENT_W-1:0] new_ent;
   logic [CNT_W-1:0] room_cnt, used_cnt;
   logic [CNT_W+OUT_W-1:0] room_ext, used_ext;
   logic [CNT_W:0]   off_inc, lvl_size;

   logic             head_vld, head_swap;
   logic [ENT_W-1:0] head_val;
   logic [CNT_W-1:0] head_off;

   // Links of the level chain; index is the level that receives.
   logic             dt_vld  [1:NC+1];
   logic [ENT_W-1:0] dt_val  [1:NC+1];
   logic [CNT_W-1:0] dt_off  [1:NC+1];
   logic             drd_en  [1:NC+1];
   logic [CNT_W-1:0] drd_row [1:NC+1];
   logic             wd_en   [1:NC+1];
   logic [CNT_W-1:0] wd_off  [1:NC+1];
   logic [ENT_W-1:0] wd_val  [1:NC+1];
   logic             ut_vld  [0:NC];
   logic [ENT_W-1:0] ut_val  [0:NC];
   logic [CNT_W-1:0] ut_off  [0:NC];
   logic             urd_en  [0:NC];
   logic [CNT_W-1:0] urd_row [0:NC];
   logic             wu_en   [0:NC];
   logic [CNT_W-1:0] wu_off  [0:NC];
   logic [ENT_W-1:0] wu_val  [0:NC];
   logic [NC:1]      fin;

   assign req_arrival   = req_tdata[DEP_W-1:0];
   assign req_departure = req_tdata[2*DEP_W-1:DEP_W];
   assign req_tag       = req_tdata[REQ_W-1:2*DEP_W];

   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign reuse     = (count_ff != '0) && (root_ff[ENT_W-1:CNT_W] < req_arrival);
   assign full      = count_ff == CAP_CNT;
   assign push      = !reuse && !full;
   assign push_root = push && (slot_lvl_ff == LVL_W'(0));
   assign push_l1   = push && (slot_lvl_ff == LVL_W'(1));
   assign push_deep = push && (slot_lvl_ff > LVL_W'(1));
   assign cnt_inc   = count_ff + CNT_W'(1);
   assign new_ent   = {req_departure, reuse ? root_ff[CNT_W-1:0] : cnt_inc};
   assign room_cnt  = reuse ? root_ff[CNT_W-1:0] : (push ? cnt_inc : '0);
   assign used_cnt  = push ? cnt_inc : count_ff;
   assign room_ext  = {{OUT_W{1'b0}}, room_cnt};
   assign used_ext  = {{OUT_W{1'b0}}, used_cnt};
   assign off_inc   = {1'b0, slot_off_ff} + (CNT_W + 1)'(1);
   assign lvl_size  = {{CNT_W{1'b0}}, 1'b1} << slot_lvl_ff;

   // The root register is the head of the chain: it settles a sift-up that
   // reaches level one, whether it came up the chain or is a fresh push.
   assign head_vld  = ut_vld[0] || (accept && push_l1);
   assign head_val  = ut_vld[0] ? ut_val[0] : new_ent;
   assign head_off  = ut_vld[0] ? ut_off[0] : slot_off_ff;
   assign head_swap = root_ff > head_val;

   assign dt_vld[1]  = inj_dn_ff;
   assign dt_val[1]  = inj_val_ff;
   assign dt_off[1]  = '0;
   assign drd_en[1]  = accept && reuse;
   assign drd_row[1] = '0;
   assign wd_en[1]   = head_vld;
   assign wd_off[1]  = head_off;
   assign wd_val[1]  = head_swap ? root_ff : head_val;
   assign ut_vld[NC]  = 1'b0;
   assign ut_val[NC]  = '0;
   assign ut_off[NC]  = '0;
   assign urd_en[NC]  = 1'b0;
   assign urd_row[NC] = '0;
   assign wu_en[NC]   = 1'b0;
   assign wu_off[NC]  = '0;
   assign wu_val[NC]  = '0;

   for (genvar g = 1; g <= NC; g++) begin : g_level
      logic             rd_en;
      logic [CNT_W-1:0] rd_row;
      logic             inj_hit;
      logic             ut_in_vld;
      logic [ENT_W-1:0] ut_in_val;
      logic [CNT_W-1:0] ut_in_off;

      // A new slot at level g+1 starts its sift-up in this level.
      assign inj_hit   = inj_up_ff && (inj_lvl_ff == LVL_W'(g + 1));
      assign rd_en     = drd_en[g] || urd_en[g] ||
                         (accept && push_deep && (slot_lvl_ff == LVL_W'(g + 1)));
      assign rd_row    = drd_en[g] ? drd_row[g] :
                         (urd_en[g] ? urd_row[g] : (slot_off_ff >> 2));
      assign ut_in_vld = ut_vld[g] || inj_hit;
      assign ut_in_val = ut_vld[g] ? ut_val[g] : inj_val_ff;
      assign ut_in_off = ut_vld[g] ? ut_off[g] : inj_off_ff;

      ramh_level_cell #(
         .LEVEL (g),
         .CNT_W (CNT_W)
      ) u_lvl (
         .clock       (clock),
         .reset       (reset),
         .count_i     (count_ff),
         .rd_en_i     (rd_en),
         .rd_row_i    (rd_row),
         .dtok_vld_i  (dt_vld[g]),
         .dtok_val_i  (dt_val[g]),
         .dtok_off_i  (dt_off[g]),
         .utok_vld_i  (ut_in_vld),
         .utok_val_i  (ut_in_val),
         .utok_off_i  (ut_in_off),
         .wa_en_i     (wd_en[g]),
         .wa_off_i    (wd_off[g]),
         .wa_val_i    (wd_val[g]),
         .wb_en_i     (wu_en[g]),
         .wb_off_i    (wu_off[g]),
         .wb_val_i    (wu_val[g]),
         .dtok_vld_o  (dt_vld[g+1]),
         .dtok_val_o  (dt_val[g+1]),
         .dtok_off_o  (dt_off[g+1]),
         .dn_rd_en_o  (drd_en[g+1]),
         .dn_rd_row_o (drd_row[g+1]),
         .wd_en_o     (wd_en[g+1]),
         .wd_off_o    (wd_off[g+1]),
         .wd_val_o    (wd_val[g+1]),
         .utok_vld_o  (ut_vld[g-1]),
         .utok_val_o  (ut_val[g-1]),
         .utok_off_o  (ut_off[g-1]),
         .up_rd_en_o  (urd_en[g-1]),
         .up_rd_row_o (urd_row[g-1]),
         .wu_en_o     (wu_en[g-1]),
         .wu_off_o    (wu_off[g-1]),
         .wu_val_o    (wu_val[g-1]),
         .fin_o       (fin[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         slot_lvl_ff  <= '0;
         slot_off_ff  <= '0;
         inj_dn_ff    <= 1'b0;
         inj_up_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inj_dn_ff <= accept && reuse;
         inj_up_ff <= accept && push_deep;
         if (accept && (reuse || push_deep)) begin
            busy_ff <= 1'b1;
         end else if ((fin != '0) || ut_vld[0]) begin
            busy_ff <= 1'b0;
         end
         if (accept && push) begin
            count_ff <= cnt_inc;
            if (off_inc == lvl_size) begin
               slot_lvl_ff <= slot_lvl_ff + LVL_W'(1);
               slot_off_ff <= '0;
            end else begin
               slot_off_ff <= off_inc[CNT_W-1:0];
            end
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (head_vld && head_swap) begin
         root_ff <= head_val;
      end else if (wu_en[0]) begin
         root_ff <= wu_val[0];
      end else if (accept && push_root) begin
         root_ff <= new_ent;
      end
      if (accept) begin
         inj_lvl_ff  <= slot_lvl_ff;
         inj_val_ff  <= new_ent;
         inj_off_ff  <= slot_off_ff;
         rsp_room_ff <= room_ext[OUT_W-1:0];
         rsp_used_ff <= used_ext[OUT_W-1:0];
         rsp_ovf_ff  <= !reuse && full;
         rsp_tag_ff  <= req_tag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_tag_ff, rsp_used_ff, rsp_room_ff};
   assign rsp_tuser  = rsp_ovf_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("room count beyond capacity");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !inj_dn_ff && !inj_up_ff && (fin == '0) && !ut_vld[0])
      else $error("heap activity while idle");

   a_single_walk: assert property (@(posedge clock) disable iff (reset)
      $onehot0({fin, ut_vld[0]}))
      else $error("more than one heap walk finishing");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && push |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("new room did not advance the count");

   a_ovf_room: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_room_ff == '0)
      else $error("overflow response carries a room");

endmodule
